// ----- hdl/heater_pi_time_proportional_control_defines.svh -----
// Assertion macros shared by the heater controller RTL.
`ifndef HEATER_PI_TIME_PROPORTIONAL_CONTROL_DEFINES_SVH
`define HEATER_PI_TIME_PROPORTIONAL_CONTROL_DEFINES_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define HPI_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("heater controller check failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define HPI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("heater controller check failed");

`endif

// ----- hdl/hpitpc_pkg.sv -----
// Shared constants and types of the heater PI controller.
`default_nettype none
package hpitpc_pkg;

    // Serial multiplier operand widths: signed multiplicand, unsigned multiplier.
    localparam int MUL_AW = 21;
    localparam int GAIN_W = 20;

    // Serial divider: dividend and divisor width, quotient bits.
    localparam int DIV_NW = 32;
    localparam int DIV_QW = 16;

    // Fixed-point shifts.
    localparam int GAIN_SHIFT = 8;
    localparam int FRAC_BITS  = 16;

    // Configuration port.
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET_TEMP     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_PROP       = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN_INTEG      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FEED_FORWARD    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_INTEG_LIMIT     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVATION_TEMP = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL_MV      = 3'd6;

    typedef logic signed [15:0] temp_t;
    typedef logic signed [17:0] duty_t;
    typedef logic [15:0]        mv_t;
    typedef logic [47:0]        stamp_t;

endpackage
`default_nettype wire

// ----- hdl/hpitpc_ser_mul.sv -----
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
`default_nettype none
module hpitpc_ser_mul
    import hpitpc_pkg::*;
#(
    parameter int AW = MUL_AW,
    parameter int BW = GAIN_W
)
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    start,
    input  wire logic signed [AW-1:0]    a,
    input  wire logic [BW-1:0]           b,
    output logic                         done,
    output logic signed [AW+BW-1:0]      prod
);

    localparam int PW = AW + BW;
    localparam int CW = $clog2(BW + 1);

    logic signed [PW-1:0] acc_reg, acc_next;
    logic signed [PW-1:0] a_reg, a_next;
    logic [BW-1:0]        b_reg, b_next;
    logic [CW-1:0]        cnt_reg, cnt_next;
    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;

    always_comb
    begin
        acc_next  = acc_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            acc_next  = '0;
            a_next    = PW'(a);
            b_next    = b;
            cnt_next  = CW'(BW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (b_reg[0])
            begin
                acc_next = acc_reg + a_reg;
            end
            a_next   = a_reg <<< 1;
            b_next   = b_reg >> 1;
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg  <= '0;
            a_reg    <= '0;
            b_reg    <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            acc_reg  <= acc_next;
            a_reg    <= a_next;
            b_reg    <= b_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign prod = acc_reg;

endmodule
`default_nettype wire

// ----- hdl/hpitpc_ser_div.sv -----
// Restoring divider producing one quotient bit per cycle; dividend below divisor.
`default_nettype none
module hpitpc_ser_div
    import hpitpc_pkg::*;
#(
    parameter int NW = DIV_NW,
    parameter int QW = DIV_QW
)
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] num,
    input  wire logic [NW-1:0] den,
    output logic               done,
    output logic [QW-1:0]      quot
);

    localparam int CW = $clog2(QW + 1);

    logic [NW-1:0] rem_reg, rem_next;
    logic [NW-1:0] den_reg, den_next;
    logic [QW-1:0] q_reg, q_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic          done_reg, done_next;
    logic [NW:0]   rem_sh;
    logic [NW:0]   diff;

    assign rem_sh = {rem_reg, 1'b0};
    assign diff   = rem_sh - {1'b0, den_reg};

    always_comb
    begin
        rem_next  = rem_reg;
        den_next  = den_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = num;
            den_next  = den;
            q_next    = '0;
            cnt_next  = CW'(QW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!diff[NW])
            begin
                rem_next = diff[NW-1:0];
                q_next   = {q_reg[QW-2:0], 1'b1};
            end
            else
            begin
                rem_next = rem_sh[NW-1:0];
                q_next   = {q_reg[QW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rem_reg  <= '0;
            den_reg  <= '0;
            q_reg    <= '0;
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            rem_reg  <= rem_next;
            den_reg  <= den_next;
            q_reg    <= q_next;
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    assign done = done_reg;
    assign quot = q_reg;

endmodule
`default_nettype wire

// ----- hdl/heater_pi_time_proportional_control.sv -----
// Top level of the heater PI controller with time-proportional output.
`default_nettype none
`include "heater_pi_time_proportional_control_defines.svh"

// Each request is one controller wake-up and yields exactly one result. A
// wake-up that finds the heater on switches it off and goes straight to the
// output state. A wake-up without a fresh sample, or before heating has
// latched, also goes straight to the output state. A control step runs three
// products through one bit-serial multiplier, whose multiplier operand width
// BW is 20 for periods up to about one second. With supply compensation
// active and the supply above nominal, two squares, a restoring divide and
// the final scaling product follow. The next request is taken once the
// result sits in the output register, so a result waiting on the output side
// holds up only the end of the following step. Configuration writes are
// accepted every cycle and should be made while the block is idle.
module heater_pi_time_proportional_control
    import hpitpc_pkg::*;
#(
    parameter int PERIOD_US          = 10000,
    parameter int TARGET_BAND        = 640,
    parameter int BATTERY_TIMEOUT_US = 500000
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,

    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [47:0]           now_us,
    input  wire logic                  temp_valid,
    input  wire logic signed [15:0]    temperature,
    input  wire logic                  battery_valid,
    input  wire logic [15:0]           supply_mv,

    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic                       heater_drive,
    output logic [13:0]                next_delay_us,
    output logic [13:0]                on_time_us,
    output logic signed [17:0]         prop_term,
    output logic signed [17:0]         integ_term,
    output logic [16:0]                voltage_multiplier,
    output logic                       target_reached,
    output logic                       activation_latched,
    output logic signed [15:0]         last_temp,
    output logic [15:0]                supply_mv_held,

    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    // Width of an on-time or delay, and of the serial multiplier operands.
    localparam int PW  = $clog2(PERIOD_US + 1);
    localparam int BW  = (PW > GAIN_W) ? PW : GAIN_W;
    localparam int PRW = MUL_AW + BW;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_PROP  = 4'd1;
    localparam logic [3:0] ST_INTEG = 4'd2;
    localparam logic [3:0] ST_SUM   = 4'd3;
    localparam logic [3:0] ST_CHECK = 4'd4;
    localparam logic [3:0] ST_NSQ   = 4'd5;
    localparam logic [3:0] ST_VSQ   = 4'd6;
    localparam logic [3:0] ST_DIV   = 4'd7;
    localparam logic [3:0] ST_SCALE = 4'd8;
    localparam logic [3:0] ST_FLAG  = 4'd9;
    localparam logic [3:0] ST_OUT   = 4'd10;

    // Configuration registers.
    temp_t        target_temp_reg;
    logic [19:0]  gain_prop_reg;
    logic [19:0]  gain_integ_reg;
    logic [16:0]  feed_forward_reg;
    logic [16:0]  integ_limit_reg;
    temp_t        activation_temp_reg;
    mv_t          nominal_mv_reg;

    // Controller state.
    logic [3:0]         state_reg, state_next;
    logic               mul_start_reg, mul_start_next;
    logic               div_start_reg, div_start_next;
    stamp_t             now_reg, now_next;
    logic signed [16:0] err_reg, err_next;
    logic               drive_on_reg, drive_on_next;
    duty_t              integ_reg, integ_next;
    duty_t              prop_reg, prop_next;
    logic [PW-1:0]      on_time_reg, on_time_next;
    logic               latched_reg, latched_next;
    logic               target_reg, target_next;
    temp_t              temp_hold_reg, temp_hold_next;
    mv_t                volt_hold_reg, volt_hold_next;
    logic               seen_reg, seen_next;
    stamp_t             stamp_reg, stamp_next;
    logic [16:0]        mult_reg, mult_next;
    logic [DIV_NW-1:0]  nsq_reg, nsq_next;
    logic [DIV_NW-1:0]  vsq_reg, vsq_next;
    logic [PW-1:0]      delay_reg, delay_next;

    // Output register.
    logic               out_valid_reg, out_valid_next;
    logic               o_drive_reg;
    logic [PW-1:0]      o_delay_reg;
    logic [PW-1:0]      o_on_time_reg;
    duty_t              o_prop_reg;
    duty_t              o_integ_reg;
    logic [16:0]        o_mult_reg;
    logic               o_target_reg;
    logic               o_latched_reg;
    temp_t              o_temp_reg;
    mv_t                o_volt_reg;
    logic               out_load;

    // Shared arithmetic units.
    logic signed [MUL_AW-1:0] mul_a;
    logic [BW-1:0]            mul_b;
    logic                     mul_done;
    logic signed [PRW-1:0]    mul_prod;
    logic                     div_done;
    logic [DIV_QW-1:0]        div_quot;

    // Datapath helpers.
    logic signed [16:0] err_in;
    logic signed [19:0] duty_sum;
    logic signed [PRW-1:0] p8;
    logic signed [PRW-1:0] isum;
    logic signed [PRW-1:0] lim;
    logic signed [PRW-1:0] tsh;
    stamp_t             elapsed;
    logic               stale;
    logic signed [17:0] err18;
    logic [17:0]        err_mag;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_temp_reg     <= 16'sd14080;
            gain_prop_reg       <= 20'd65536;
            gain_integ_reg      <= 20'd1638;
            feed_forward_reg    <= 17'd3277;
            integ_limit_reg     <= 17'd65536;
            activation_temp_reg <= 16'sd32767;
            nominal_mv_reg      <= 16'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_TARGET_TEMP:     target_temp_reg     <= cfg_data[15:0];
                CFG_GAIN_PROP:       gain_prop_reg       <= cfg_data[19:0];
                CFG_GAIN_INTEG:      gain_integ_reg      <= cfg_data[19:0];
                CFG_FEED_FORWARD:    feed_forward_reg    <= cfg_data[16:0];
                CFG_INTEG_LIMIT:     integ_limit_reg     <= cfg_data[16:0];
                CFG_ACTIVATION_TEMP: activation_temp_reg <= cfg_data[15:0];
                CFG_NOMINAL_MV:      nominal_mv_reg      <= cfg_data[15:0];
                default:             ;
            endcase
        end
    end

    assign err_in   = 17'(target_temp_reg) - 17'(temperature);
    assign duty_sum = $signed({3'b000, feed_forward_reg}) + 20'(prop_reg) + 20'(integ_reg);
    assign p8       = mul_prod >>> GAIN_SHIFT;
    assign isum     = p8 + PRW'(integ_reg);
    assign lim      = $signed(PRW'(integ_limit_reg));
    assign tsh      = mul_prod >>> FRAC_BITS;
    assign elapsed  = now_reg - stamp_reg;
    assign stale    = !seen_reg || (elapsed > 48'(BATTERY_TIMEOUT_US));
    assign err18    = 18'(err_reg);
    assign err_mag  = err18[17] ? 18'(-err18) : 18'(err18);

    // Operand selection for the serial multiplier, by step.
    always_comb
    begin
        unique case (state_reg)
            ST_PROP:
            begin
                mul_a = MUL_AW'(err_reg);
                mul_b = BW'(gain_prop_reg);
            end
            ST_INTEG:
            begin
                mul_a = MUL_AW'(err_reg);
                mul_b = BW'(gain_integ_reg);
            end
            ST_SUM:
            begin
                mul_a = MUL_AW'(duty_sum);
                mul_b = BW'(PERIOD_US);
            end
            ST_NSQ:
            begin
                mul_a = $signed(MUL_AW'(nominal_mv_reg));
                mul_b = BW'(nominal_mv_reg);
            end
            ST_VSQ:
            begin
                mul_a = $signed(MUL_AW'(volt_hold_reg));
                mul_b = BW'(volt_hold_reg);
            end
            ST_SCALE:
            begin
                mul_a = $signed(MUL_AW'(on_time_reg));
                mul_b = BW'(mult_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign out_load = (state_reg == ST_OUT) && (!out_valid_reg || out_ready);

    always_comb
    begin
        state_next     = state_reg;
        mul_start_next = 1'b0;
        div_start_next = 1'b0;
        now_next       = now_reg;
        err_next       = err_reg;
        drive_on_next  = drive_on_reg;
        integ_next     = integ_reg;
        prop_next      = prop_reg;
        on_time_next   = on_time_reg;
        latched_next   = latched_reg;
        target_next    = target_reg;
        temp_hold_next = temp_hold_reg;
        volt_hold_next = volt_hold_reg;
        seen_next      = seen_reg;
        stamp_next     = stamp_reg;
        mult_next      = mult_reg;
        nsq_next       = nsq_reg;
        vsq_next       = vsq_reg;
        delay_next     = delay_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    now_next   = now_us;
                    err_next   = err_in;
                    delay_next = PW'(PERIOD_US);
                    // A battery report is stored first, whichever branch follows.
                    if (battery_valid)
                    begin
                        volt_hold_next = supply_mv;
                        stamp_next     = now_us;
                        seen_next      = 1'b1;
                    end
                    state_next = ST_OUT;
                    if (drive_on_reg)
                    begin
                        // End of the on phase: wait out the rest of the period.
                        drive_on_next = 1'b0;
                        delay_next    = PW'(PERIOD_US) - on_time_reg;
                    end
                    else if (temp_valid)
                    begin
                        temp_hold_next = temperature;
                        if (temperature < activation_temp_reg)
                        begin
                            latched_next = 1'b1;
                        end
                        if (latched_reg || (temperature < activation_temp_reg))
                        begin
                            state_next     = ST_PROP;
                            mul_start_next = 1'b1;
                        end
                    end
                end
            end
            ST_PROP:
            begin
                if (mul_done)
                begin
                    if (p8 > PRW'(131071))
                        prop_next = 18'sd131071;
                    else if (p8 < PRW'(-131072))
                        prop_next = -18'sd131072;
                    else
                        prop_next = 18'(p8);
                    state_next     = ST_INTEG;
                    mul_start_next = 1'b1;
                end
            end
            ST_INTEG:
            begin
                if (mul_done)
                begin
                    if (isum > lim)
                        integ_next = 18'(lim);
                    else if (isum < -lim)
                        integ_next = 18'(-lim);
                    else
                        integ_next = 18'(isum);
                    state_next     = ST_SUM;
                    mul_start_next = 1'b1;
                end
            end
            ST_SUM:
            begin
                if (mul_done)
                begin
                    if (tsh < 0)
                        on_time_next = '0;
                    else if (tsh > PRW'(PERIOD_US))
                        on_time_next = PW'(PERIOD_US);
                    else
                        on_time_next = PW'(tsh);
                    state_next = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                state_next = ST_FLAG;
                if (nominal_mv_reg != '0)
                begin
                    if (stale)
                    begin
                        on_time_next = '0;
                    end
                    else if (volt_hold_reg > nominal_mv_reg)
                    begin
                        state_next     = ST_NSQ;
                        mul_start_next = 1'b1;
                    end
                end
            end
            ST_NSQ:
            begin
                if (mul_done)
                begin
                    nsq_next       = mul_prod[DIV_NW-1:0];
                    state_next     = ST_VSQ;
                    mul_start_next = 1'b1;
                end
            end
            ST_VSQ:
            begin
                if (mul_done)
                begin
                    vsq_next       = mul_prod[DIV_NW-1:0];
                    state_next     = ST_DIV;
                    div_start_next = 1'b1;
                end
            end
            ST_DIV:
            begin
                if (div_done)
                begin
                    // The supply is above nominal, so the ratio stays below one.
                    mult_next      = 17'(div_quot);
                    state_next     = ST_SCALE;
                    mul_start_next = 1'b1;
                end
            end
            ST_SCALE:
            begin
                if (mul_done)
                begin
                    on_time_next = mul_prod[FRAC_BITS +: PW];
                    state_next   = ST_FLAG;
                end
            end
            ST_FLAG:
            begin
                target_next = err_mag < 18'(TARGET_BAND);
                if (on_time_reg != '0)
                begin
                    drive_on_next = 1'b1;
                    delay_next    = on_time_reg;
                end
                state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mul_start_reg <= 1'b0;
            div_start_reg <= 1'b0;
            now_reg       <= '0;
            err_reg       <= '0;
            drive_on_reg  <= 1'b0;
            integ_reg     <= '0;
            prop_reg      <= '0;
            on_time_reg   <= '0;
            latched_reg   <= 1'b0;
            target_reg    <= 1'b0;
            temp_hold_reg <= '0;
            volt_hold_reg <= '0;
            seen_reg      <= 1'b0;
            stamp_reg     <= '0;
            mult_reg      <= 17'd65536;
            nsq_reg       <= '0;
            vsq_reg       <= '0;
            delay_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mul_start_reg <= mul_start_next;
            div_start_reg <= div_start_next;
            now_reg       <= now_next;
            err_reg       <= err_next;
            drive_on_reg  <= drive_on_next;
            integ_reg     <= integ_next;
            prop_reg      <= prop_next;
            on_time_reg   <= on_time_next;
            latched_reg   <= latched_next;
            target_reg    <= target_next;
            temp_hold_reg <= temp_hold_next;
            volt_hold_reg <= volt_hold_next;
            seen_reg      <= seen_next;
            stamp_reg     <= stamp_next;
            mult_reg      <= mult_next;
            nsq_reg       <= nsq_next;
            vsq_reg       <= vsq_next;
            delay_reg     <= delay_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // The result fields copy the state as it stands at the end of the step.
    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            o_drive_reg   <= drive_on_reg;
            o_delay_reg   <= delay_reg;
            o_on_time_reg <= on_time_reg;
            o_prop_reg    <= prop_reg;
            o_integ_reg   <= integ_reg;
            o_mult_reg    <= mult_reg;
            o_target_reg  <= target_reg;
            o_latched_reg <= latched_reg;
            o_temp_reg    <= temp_hold_reg;
            o_volt_reg    <= volt_hold_reg;
        end
    end

    hpitpc_ser_mul #(
        .AW (MUL_AW),
        .BW (BW)
    ) u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start_reg),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    hpitpc_ser_div #(
        .NW (DIV_NW),
        .QW (DIV_QW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start_reg),
        .num   (nsq_reg),
        .den   (vsq_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    assign in_ready           = (state_reg == ST_IDLE);
    assign out_valid          = out_valid_reg;
    assign heater_drive       = o_drive_reg;
    assign next_delay_us      = 14'(o_delay_reg);
    assign on_time_us         = 14'(o_on_time_reg);
    assign prop_term          = o_prop_reg;
    assign integ_term         = o_integ_reg;
    assign voltage_multiplier = o_mult_reg;
    assign target_reached     = o_target_reg;
    assign activation_latched = o_latched_reg;
    assign last_temp          = o_temp_reg;
    assign supply_mv_held     = o_volt_reg;

    `HPI_ASSERT_NEXT(a_accept_leaves_idle, in_valid && in_ready, state_reg != ST_IDLE)
    `HPI_ASSERT_IMPLY(a_on_time_bound, 1'b1, on_time_reg <= PW'(PERIOD_US))
    `HPI_ASSERT_IMPLY(a_drive_has_on_time, drive_on_reg, on_time_reg != '0)
    `HPI_ASSERT_IMPLY(a_mul_done_in_step, mul_done, state_reg == ST_PROP || state_reg == ST_INTEG || state_reg == ST_SUM || state_reg == ST_NSQ || state_reg == ST_VSQ || state_reg == ST_SCALE)

endmodule
`default_nettype wire
